/* rtl/core/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// Partition fit allocator package
// Field widths, status and policy codes, register indexes and shared structs.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int BLOCK_W  = 4;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd1;

  localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

  typedef struct packed {
    logic [POLICY_W-1:0] policy;
    logic [COUNT_W-1:0]  block_count;
  } pfa_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  chosen_block;
    logic [SIZE_W-1:0]   remaining;
    logic                batch_done;
  } pfa_result_t;

endpackage

/* rtl/core/pfa_if.sv */
// ----------------------------------------------------------------------------
// Partition fit allocator channels
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface pfa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [pfa_pkg::BLOCK_W-1:0] block_index;
  logic [pfa_pkg::SIZE_W-1:0]  size_value;
  logic                       batch_end;

  modport source (output valid, action, block_index, size_value, batch_end,
                  input ready);
  modport sink (input valid, action, block_index, size_value, batch_end,
                output ready);
endinterface

interface pfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::STATUS_W-1:0] status;
  logic [pfa_pkg::BLOCK_W-1:0]  chosen_block;
  logic [pfa_pkg::SIZE_W-1:0]   remaining;
  logic                        batch_done;

  modport source (output valid, status, chosen_block, remaining, batch_done,
                  input ready);
  modport sink (input valid, status, chosen_block, remaining, batch_done,
                output ready);
endinterface

interface pfa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pfa_pkg::CFG_IDX_W-1:0]  index;
  logic [pfa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/partition_fit_allocator_top.sv */
// ----------------------------------------------------------------------------
// Partition fit allocator top level
// Configuration registers, scan engine and response output register.
// ----------------------------------------------------------------------------
// A load goes from acceptance to the result state, then the output register.
// A request reads N entries, N the entries in use (min of block_count and
// MAX_BLOCKS): one table read per cycle, then drain, evaluation, write-back.
// One request is in work at a time; the next is taken once the result sits in
// the output register. Reset sets first fit and 16 entries in use; table
// contents are undefined until loaded and no clearing pass runs.
module partition_fit_allocator_top #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst,
  pfa_req_if.sink  req,
  pfa_rsp_if.source rsp,
  pfa_cfg_if.sink  cfg
);

  pfa_pkg::pfa_cfg_t    cfg_q;
  pfa_pkg::pfa_result_t res;
  pfa_pkg::pfa_result_t out_data;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.policy      <= pfa_pkg::POLICY_RESET;
      cfg_q.block_count <= pfa_pkg::COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == pfa_pkg::CFG_POLICY) begin
        cfg_q.policy <= cfg.data[pfa_pkg::POLICY_W-1:0];
      end else if (cfg.index == pfa_pkg::CFG_COUNT) begin
        cfg_q.block_count <= cfg.data[pfa_pkg::COUNT_W-1:0];
      end
    end
  end

  pfa_engine #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg_q),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.chosen_block = out_data.chosen_block;
  assign rsp.remaining    = out_data.remaining;
  assign rsp.batch_done   = out_data.batch_done;

endmodule

/* rtl/core/pfa_ram.sv */
// ----------------------------------------------------------------------------
// Partition fit allocator RAM
// Simple dual-port synchronous RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pfa_engine.sv */
// ----------------------------------------------------------------------------
// Partition fit allocator engine
// Scans the free size table one entry a cycle, picks a block by policy and
// writes the reduced free size back; a load writes a size straight into the table.
// ----------------------------------------------------------------------------
module pfa_engine #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  pfa_req_if.sink              req,
  input  pfa_pkg::pfa_cfg_t    cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pfa_pkg::pfa_result_t res
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                    state;
  logic [IW-1:0]                 rd_cnt;
  logic [IW-1:0]                 n_use;
  logic [SIZE_BITS-1:0]          req_size;
  logic [pfa_pkg::POLICY_W-1:0]  pol;
  logic                          batch;
  logic                          dv;
  logic [AW-1:0]                 dv_idx;
  logic                          found;
  logic [AW-1:0]                 pick_idx;
  logic [SIZE_BITS-1:0]          pick_val;

  logic                          pend_we;
  logic [AW-1:0]                 pend_waddr;
  logic [SIZE_BITS-1:0]          pend_wdata;
  logic [pfa_pkg::STATUS_W-1:0]  pend_status;
  logic [pfa_pkg::BLOCK_W-1:0]   pend_block;
  logic [pfa_pkg::SIZE_W-1:0]    pend_rem;

  logic                          req_fire;
  logic [IW-1:0]                 n_in;
  logic [SIZE_BITS-1:0]          in_size;
  logic                          idx_ok;
  logic [SIZE_BITS-1:0]          rd_data;
  logic                          fits;
  logic                          take;
  logic [SIZE_BITS-1:0]          left;
  logic                          ram_we;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign in_size   = SIZE_BITS'(req.size_value);
  assign idx_ok    = int'(req.block_index) < MAX_BLOCKS;
  assign left      = pick_val - req_size;

  always_comb begin
    if (int'(cfg.block_count) > MAX_BLOCKS) begin
      n_in = IW'(MAX_BLOCKS);
    end else begin
      n_in = IW'(cfg.block_count);
    end
  end

  assign fits = rd_data >= req_size;
  assign take = dv && fits &&
                (!found ||
                 (pol == pfa_pkg::POL_BEST  && rd_data < pick_val) ||
                 (pol == pfa_pkg::POL_WORST && rd_data > pick_val));

  assign ram_we = (state == S_FIN) && res_ready && pend_we;

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (state == S_SCAN),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dv    <= 1'b0;
      found <= 1'b0;
    end else begin
      dv     <= (state == S_SCAN);
      dv_idx <= rd_cnt[AW-1:0];
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            batch    <= req.batch_end;
            req_size <= in_size;
            pol      <= cfg.policy;
            n_use    <= n_in;
            rd_cnt   <= '0;
            found    <= 1'b0;
            if (req.action == pfa_pkg::ACT_LOAD) begin
              pend_we     <= idx_ok;
              pend_waddr  <= AW'(req.block_index);
              pend_wdata  <= in_size;
              pend_status <= idx_ok ? pfa_pkg::ST_LOADED : pfa_pkg::ST_BADIDX;
              pend_block  <= req.block_index;
              pend_rem    <= idx_ok ? pfa_pkg::SIZE_W'(in_size) : '0;
              state       <= S_FIN;
            end else if (n_in == '0) begin
              pend_we     <= 1'b0;
              pend_status <= pfa_pkg::ST_NOFIT;
              pend_block  <= '0;
              pend_rem    <= '0;
              state       <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_cnt <= rd_cnt + IW'(1);
          if (rd_cnt + IW'(1) == n_use) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          pend_we     <= found;
          pend_waddr  <= pick_idx;
          pend_wdata  <= left;
          pend_status <= found ? pfa_pkg::ST_ALLOC : pfa_pkg::ST_NOFIT;
          pend_block  <= found ? pfa_pkg::BLOCK_W'(pick_idx) : '0;
          pend_rem    <= found ? pfa_pkg::SIZE_W'(left) : '0;
          state       <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (take) begin
        found    <= 1'b1;
        pick_idx <= dv_idx;
        pick_val <= rd_data;
      end
    end
  end

  assign res_valid        = (state == S_FIN);
  assign res.status       = pend_status;
  assign res.chosen_block = pend_block;
  assign res.remaining    = pend_rem;
  assign res.batch_done   = batch;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state != S_IDLE)
    else $error("accepted request did not start work");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> rd_cnt < n_use)
    else $error("scan read beyond entries in use");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pend_status == pfa_pkg::ST_ALLOC) |-> pick_idx < n_use)
    else $error("allocated block outside entries in use");

  a_data_follows_read: assert property (@(posedge clk) disable iff (rst)
    dv |-> $past(state) == S_SCAN)
    else $error("read data flagged without a read");
`endif

endmodule
